[src/fsms_pkg.sv]
package fsms_pkg;

  localparam int QUERY_MAX = 32;
  localparam int NAME_MAX  = 255;
  localparam int CHAR_W    = 16;
  localparam int SCORE_W   = 16;

  localparam int QIDX_W  = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
  localparam int QLEN_W  = $clog2(QUERY_MAX + 1);
  localparam int NAME_W  = $clog2(NAME_MAX + 1);

  localparam int FIRST_GAP_WEIGHT = 10;
  localparam int LATER_GAP_WEIGHT = 80;

  localparam int TERM_W  = NAME_W + 7;
  localparam int SUM_W   = ((TERM_W > SCORE_W) ? TERM_W : SCORE_W) + 1;
  localparam int PROD_W  = QLEN_W + NAME_W;
  localparam int TOTAL_W = ((PROD_W > SCORE_W) ? PROD_W : SCORE_W) + 1;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_NAME   = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } item_t;

  typedef struct packed {
    logic [QLEN_W-1:0]  query_length;
    logic [NAME_W-1:0]  name_length;
    logic [SCORE_W-1:0] gap_sum;
    logic               empty;
    logic               matched;
  } tally_t;

endpackage

[src/fsms_match.sv]
module fsms_match (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  fsms_pkg::item_t item,
  output logic            tally_valid,
  input  logic            tally_ready,
  output fsms_pkg::tally_t tally
);

  logic [fsms_pkg::CHAR_W-1:0] query_store [fsms_pkg::QUERY_MAX];

  logic [fsms_pkg::QLEN_W-1:0]  query_length, query_length_next;
  logic [fsms_pkg::QLEN_W-1:0]  match_pointer, match_pointer_next;
  logic [fsms_pkg::NAME_W-1:0]  resume_position, resume_position_next;
  logic [fsms_pkg::NAME_W-1:0]  name_position, name_position_next;
  logic [fsms_pkg::SCORE_W-1:0] gap_sum, gap_sum_next;

  logic [fsms_pkg::CHAR_W-1:0]  query_char;
  logic                         in_range;
  logic                         hit;
  logic [fsms_pkg::NAME_W-1:0]  gap;
  logic [fsms_pkg::TERM_W-1:0]  term;
  logic [fsms_pkg::SUM_W-1:0]   sum;
  logic [fsms_pkg::SCORE_W-1:0] gap_sum_hit;
  logic [fsms_pkg::NAME_W-1:0]  name_position_adv;
  logic                         fire;
  logic                         emit;
  logic                         append_ok;
  fsms_pkg::tally_t             tally_next;

  function automatic logic [fsms_pkg::CHAR_W-1:0] fold_case(
    input logic [fsms_pkg::CHAR_W-1:0] c
  );
    logic [fsms_pkg::CHAR_W-1:0] r;
    r = c;
    if (c >= fsms_pkg::CHAR_W'("A") && c <= fsms_pkg::CHAR_W'("Z")) begin
      r = c + fsms_pkg::CHAR_W'(32);
    end
    return r;
  endfunction

  assign item_ready = !tally_valid || tally_ready;
  assign fire       = item_valid && item_ready;
  assign emit       = fire && (item.op == fsms_pkg::OP_NAME) && item.last_char;
  assign append_ok  = query_length < fsms_pkg::QLEN_W'(fsms_pkg::QUERY_MAX);

  always_comb begin
    query_char = query_store[match_pointer[fsms_pkg::QIDX_W-1:0]];
    in_range   = name_position < fsms_pkg::NAME_W'(fsms_pkg::NAME_MAX);
    hit        = in_range && (match_pointer < query_length) &&
                 (fold_case(query_char) == fold_case(item.char_code));
    gap        = name_position - resume_position;
    if (gap == '0) begin
      term = fsms_pkg::TERM_W'(1);
    end else if (match_pointer == '0) begin
      term = fsms_pkg::TERM_W'(gap) * fsms_pkg::TERM_W'(fsms_pkg::FIRST_GAP_WEIGHT);
    end else begin
      term = fsms_pkg::TERM_W'(gap) * fsms_pkg::TERM_W'(fsms_pkg::LATER_GAP_WEIGHT);
    end
    sum = fsms_pkg::SUM_W'(gap_sum) + fsms_pkg::SUM_W'(term);
    if (sum > fsms_pkg::SUM_W'(fsms_pkg::SCORE_MAX)) begin
      gap_sum_hit = fsms_pkg::SCORE_MAX;
    end else begin
      gap_sum_hit = sum[fsms_pkg::SCORE_W-1:0];
    end
    name_position_adv = in_range ? name_position + fsms_pkg::NAME_W'(1) : name_position;

    query_length_next    = query_length;
    match_pointer_next   = match_pointer;
    resume_position_next = resume_position;
    name_position_next   = name_position;
    gap_sum_next         = gap_sum;

    case (item.op)
      fsms_pkg::OP_CLEAR: begin
        query_length_next    = '0;
        match_pointer_next   = '0;
        resume_position_next = '0;
        name_position_next   = '0;
        gap_sum_next         = '0;
      end
      fsms_pkg::OP_APPEND: begin
        if (append_ok) begin
          query_length_next = query_length + fsms_pkg::QLEN_W'(1);
        end
        match_pointer_next   = '0;
        resume_position_next = '0;
        name_position_next   = '0;
        gap_sum_next         = '0;
      end
      fsms_pkg::OP_NAME: begin
        if (hit) begin
          match_pointer_next   = match_pointer + fsms_pkg::QLEN_W'(1);
          resume_position_next = name_position + fsms_pkg::NAME_W'(1);
          gap_sum_next         = gap_sum_hit;
        end
        name_position_next = name_position_adv;
      end
      default: begin
      end
    endcase

    tally_next.query_length = query_length;
    tally_next.name_length  = name_position_next;
    tally_next.gap_sum      = gap_sum_next;
    tally_next.empty        = query_length == '0;
    tally_next.matched      = (query_length == '0) || (match_pointer_next >= query_length);

    if (item.op == fsms_pkg::OP_NAME && item.last_char) begin
      match_pointer_next   = '0;
      resume_position_next = '0;
      name_position_next   = '0;
      gap_sum_next         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_length    <= '0;
      match_pointer   <= '0;
      resume_position <= '0;
      name_position   <= '0;
      gap_sum         <= '0;
      tally_valid     <= 1'b0;
    end else begin
      if (fire) begin
        query_length    <= query_length_next;
        match_pointer   <= match_pointer_next;
        resume_position <= resume_position_next;
        name_position   <= name_position_next;
        gap_sum         <= gap_sum_next;
      end
      if (emit) begin
        tally_valid <= 1'b1;
      end else if (tally_ready) begin
        tally_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tally <= tally_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && item.op == fsms_pkg::OP_APPEND && append_ok) begin
      query_store[query_length[fsms_pkg::QIDX_W-1:0]] <= item.char_code;
    end
  end

`ifndef SYNTH
  a_pointer_within_query: assert property (@(posedge clk) disable iff (rst)
    match_pointer <= query_length)
    else $error("match pointer beyond query length");

  a_resume_not_ahead: assert property (@(posedge clk) disable iff (rst)
    resume_position <= name_position)
    else $error("resume position ahead of name position");

  a_pointer_within_name: assert property (@(posedge clk) disable iff (rst)
    match_pointer <= name_position)
    else $error("more matches than name characters");

  a_name_bounded: assert property (@(posedge clk) disable iff (rst)
    name_position <= fsms_pkg::NAME_W'(fsms_pkg::NAME_MAX))
    else $error("name position past limit");

  a_tally_held: assert property (@(posedge clk) disable iff (rst)
    tally_valid && !tally_ready |=> tally_valid && $stable(tally))
    else $error("pending tally lost or changed");
`endif

endmodule

[src/fuzzy_subsequence_match_score_unit.sv]
// the request with the last name char passes the input, tally and output registers to m_tvalid
// throughput: one request per cycle, every opcode, unless m_tready stalls; each name char is
// one compare and one gap update against the query store entry at the match pointer
// results wait in an output register; requests are accepted until the tally register also fills
// reset (rst, synchronous): query length and name state cleared, no result pending
module fuzzy_subsequence_match_score_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // char_code[15:0]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // score[15:0]
  output logic [0:0]  m_tuser    // matched
);

  logic                         in_valid;
  logic                         in_ready;
  fsms_pkg::item_t              in_item;
  logic                         tally_valid;
  logic                         out_ready;
  fsms_pkg::tally_t             tally;
  logic [fsms_pkg::PROD_W-1:0]  prod;
  logic [fsms_pkg::TOTAL_W-1:0] total;
  logic [fsms_pkg::SCORE_W-1:0] score;

  assign s_tready  = !in_valid || in_ready;
  assign out_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op        <= fsms_pkg::op_t'(s_tuser);
      in_item.char_code <= s_tdata;
      in_item.last_char <= s_tlast;
    end
  end

  fsms_match u_match (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (in_valid),
    .item_ready  (in_ready),
    .item        (in_item),
    .tally_valid (tally_valid),
    .tally_ready (out_ready),
    .tally       (tally)
  );

  always_comb begin
    prod  = fsms_pkg::PROD_W'(tally.query_length) * fsms_pkg::PROD_W'(tally.name_length);
    total = fsms_pkg::TOTAL_W'(prod) + fsms_pkg::TOTAL_W'(tally.gap_sum);
    if (tally.empty) begin
      score = fsms_pkg::SCORE_W'(1);
    end else if (!tally.matched) begin
      score = '0;
    end else if (total > fsms_pkg::TOTAL_W'(fsms_pkg::SCORE_MAX)) begin
      score = fsms_pkg::SCORE_MAX;
    end else begin
      score = total[fsms_pkg::SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= tally_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && tally_valid) begin
      m_tdata <= score;
      m_tuser <= tally.matched;
    end
  end

endmodule

[tb/fuzzy_subsequence_match_score_unit_test.sv]
module fuzzy_subsequence_match_score_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [15:0] CH_UPPER_A = "A";
  localparam logic [15:0] CH_UPPER_Z = "Z";
  localparam logic [15:0] CH_LOWER_A = "a";
  localparam logic [15:0] CH_LOWER_Z = "z";
  localparam logic [15:0] CH_ZERO = "0";
  localparam logic [15:0] CASE_BIT = CH_LOWER_A ^ CH_UPPER_A;
  localparam int          LONG_HOLD = 400;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] code;
    logic        last_char;
  } request_t;

  typedef struct packed {
    logic [15:0] score;
    logic        matched;
  } score_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;

  fuzzy_subsequence_match_score_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  request_t    request_queue[$];
  score_t      score_queue[$];
  int unsigned failures = 0;
  int unsigned results_seen = 0;
  int unsigned requests_queued = 0;
  int unsigned cycle_count = 0;

  // scoring state
  logic [15:0] query_chars [fsms_pkg::QUERY_MAX];
  int unsigned query_len = 0;
  int unsigned match_idx = 0;
  int unsigned resume_pos = 0;
  int unsigned name_pos = 0;
  int unsigned gap_total = 0;

  // query as the generator believes it to be
  logic [15:0] gen_query[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic [15:0] fold_letter(logic [15:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return c | CASE_BIT;
    return c;
  endfunction

  function automatic bit is_letter(logic [15:0] c);
    logic [15:0] f;
    f = fold_letter(c);
    return f >= CH_LOWER_A && f <= CH_LOWER_Z;
  endfunction

  function automatic bit calm_period();
    return cycle_count[9:8] == 2'd0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_period() || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_name_state();
    match_idx = 0;
    resume_pos = 0;
    name_pos = 0;
    gap_total = 0;
  endtask

  task automatic score_request(input logic [1:0] op, input logic [15:0] code,
                               input logic last_char);
    int unsigned gap;
    int unsigned term;
    int unsigned total;
    score_t      res;
    case (op)
      fsms_pkg::OP_CLEAR: begin
        query_len = 0;
        clear_name_state();
      end
      fsms_pkg::OP_APPEND: begin
        if (query_len < fsms_pkg::QUERY_MAX) begin
          query_chars[query_len] = code;
          query_len++;
        end
        clear_name_state();
      end
      fsms_pkg::OP_NAME: begin
        if (name_pos < fsms_pkg::NAME_MAX) begin
          if (match_idx < query_len &&
              fold_letter(query_chars[match_idx]) == fold_letter(code)) begin
            gap = name_pos - resume_pos;
            if (gap == 0) term = 1;
            else if (match_idx == 0) term = fsms_pkg::FIRST_GAP_WEIGHT * gap;
            else term = fsms_pkg::LATER_GAP_WEIGHT * gap;
            gap_total = gap_total + term;
            if (gap_total > fsms_pkg::SCORE_MAX) gap_total = fsms_pkg::SCORE_MAX;
            match_idx++;
            resume_pos = name_pos + 1;
          end
          name_pos++;
        end
        if (last_char) begin
          if (query_len == 0) begin
            res.score = 16'd1;
            res.matched = 1'b1;
          end else if (match_idx >= query_len) begin
            total = query_len * name_pos + gap_total;
            if (total > fsms_pkg::SCORE_MAX) total = fsms_pkg::SCORE_MAX;
            res.score = total[15:0];
            res.matched = 1'b1;
          end else begin
            res.score = '0;
            res.matched = 1'b0;
          end
          score_queue = {score_queue, res};
          clear_name_state();
        end
      end
      default: ;
    endcase
  endtask

  // request driver
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    request_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid) begin
        score_request(s_tuser, s_tdata, s_tlast);
        gap_left = pick_gap();
      end
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        req = request_queue.pop_front();
        s_tuser  <= req.op;
        s_tdata  <= req.code;
        s_tlast  <= req.last_char;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver backpressure
  int unsigned hold_left = 0;
  bit          long_hold_done = 0;
  always @(posedge clk) begin
    int unsigned r;
    if (rst) begin
      m_tready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 40) begin
      long_hold_done = 1;
      hold_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (calm_period() || r < 70) begin
        m_tready <= 1'b1;
      end else begin
        hold_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(9, 49);
        m_tready <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    score_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (score_queue.size() == 0) begin
        $error("unexpected result: score %0d matched %0d", m_tdata, m_tuser);
        failures++;
      end else begin
        want = score_queue.pop_front();
        if (m_tdata !== want.score) begin
          $error("score mismatch: expected %0d, got %0d", want.score, m_tdata);
          failures++;
        end
        if (m_tuser[0] !== want.matched) begin
          $error("matched mismatch: expected %0d, got %0d", want.matched, m_tuser);
          failures++;
        end
      end
    end
  end

  task automatic push_request(input logic [1:0] op, input logic [15:0] code,
                              input logic last_char);
    request_t req;
    req.op = op;
    req.code = code;
    req.last_char = last_char;
    request_queue = {request_queue, req};
    if (op != OP_UNUSED) requests_queued++;
    if (op == fsms_pkg::OP_CLEAR) gen_query.delete();
    if (op == fsms_pkg::OP_APPEND && gen_query.size() < fsms_pkg::QUERY_MAX) begin
      gen_query = {gen_query, code};
    end
  endtask

  function automatic logic [15:0] rand_char();
    int unsigned r;
    logic [15:0] c;
    r = $urandom_range(0, 99);
    if (r < 45) c = CH_LOWER_A + 16'($urandom_range(0, 5));
    else if (r < 55) c = CH_LOWER_A + 16'($urandom_range(0, 25));
    else if (r < 70) begin
      case ($urandom_range(0, 3))
        0: c = CH_UPPER_A - 16'd1;
        1: c = CH_UPPER_Z + 16'd1;
        2: c = CH_LOWER_A - 16'd1;
        default: c = CH_LOWER_Z + 16'd1;
      endcase
    end else if (r < 80) c = CH_ZERO + 16'($urandom_range(0, 9));
    else c = 16'($urandom_range(0, 65535));
    if (is_letter(c) && $urandom_range(0, 1)) c = c ^ CASE_BIT;
    return c;
  endfunction

  function automatic logic [15:0] flip_case(logic [15:0] c);
    if (is_letter(c) && $urandom_range(0, 1)) return c ^ CASE_BIT;
    return c;
  endfunction

  task automatic push_name();
    logic [15:0] chars[$];
    logic [15:0] q[$];
    int unsigned abort_at;
    int unsigned n;
    q = gen_query;
    if ($urandom_range(0, 99) < 65) begin
      foreach (q[i]) begin
        n = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(10, 60);
        repeat (n) chars = {chars, rand_char()};
        chars = {chars, flip_case(q[i])};
      end
      repeat ($urandom_range(0, 3)) chars = {chars, rand_char()};
    end else begin
      repeat ($urandom_range(1, 10)) chars = {chars, rand_char()};
    end
    if ($urandom_range(0, 99) < 3) begin
      repeat ($urandom_range(230, 300)) chars = {chars, rand_char()};
    end
    if (chars.size() == 0) chars = {chars, rand_char()};
    abort_at = ($urandom_range(0, 99) < 4) ? $urandom_range(0, chars.size() - 1) : chars.size();
    foreach (chars[i]) begin
      if (i == abort_at) push_request(fsms_pkg::OP_APPEND, rand_char(), 1'($urandom_range(0, 1)));
      push_request(fsms_pkg::OP_NAME, chars[i], i == chars.size() - 1);
    end
  endtask

  task automatic push_random(input int unsigned target);
    int unsigned r;
    int unsigned k;
    while (requests_queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        push_request(fsms_pkg::OP_CLEAR, 16'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)));
        k = $urandom_range(0, 99);
        if (k < 80) k = $urandom_range(0, 5);
        else if (k < 90) k = $urandom_range(6, 31);
        else k = $urandom_range(32, 36);
        repeat (k) push_request(fsms_pkg::OP_APPEND, rand_char(), 1'($urandom_range(0, 1)));
      end else if (r < 88) begin
        push_name();
      end else if (r < 94) begin
        push_request(fsms_pkg::OP_APPEND, rand_char(), 1'($urandom_range(0, 1)));
      end else begin
        push_request(OP_UNUSED, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic wait_drained();
    while (request_queue.size() > 0 || s_tvalid) @(posedge clk);
    while (score_queue.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty query, ignored opcode, flag on clear and append
    push_request(fsms_pkg::OP_NAME, "x", 1'b1);
    push_request(OP_UNUSED, 16'hFFFF, 1'b1);
    push_request(fsms_pkg::OP_CLEAR, 16'hFFFF, 1'b1);
    push_request(fsms_pkg::OP_APPEND, "A", 1'b1);
    push_request(fsms_pkg::OP_APPEND, 16'hFFFF, 1'b0);
    push_request(fsms_pkg::OP_NAME, "a", 1'b0);
    push_request(fsms_pkg::OP_NAME, "b", 1'b0);
    push_request(fsms_pkg::OP_NAME, 16'hFFFF, 1'b1);
    // query change aborts a name in progress
    push_request(fsms_pkg::OP_NAME, "a", 1'b0);
    push_request(fsms_pkg::OP_APPEND, 16'h0000, 1'b1);
    push_request(fsms_pkg::OP_NAME, 16'h0000, 1'b1);
    // non-letters next to the letter ranges do not fold
    push_request(fsms_pkg::OP_CLEAR, 16'h0000, 1'b0);
    push_request(fsms_pkg::OP_APPEND, CH_UPPER_Z + 16'd1, 1'b0);
    push_request(fsms_pkg::OP_NAME, CH_LOWER_Z + 16'd1, 1'b1);
    push_request(fsms_pkg::OP_CLEAR, 16'h0000, 1'b0);
    push_request(fsms_pkg::OP_APPEND, "Z", 1'b0);
    push_request(fsms_pkg::OP_NAME, "q", 1'b0);
    push_request(fsms_pkg::OP_NAME, "z", 1'b1);
    push_request(fsms_pkg::OP_APPEND, CH_UPPER_A - 16'd1, 1'b0);
    push_request(fsms_pkg::OP_NAME, CH_LOWER_A - 16'd1, 1'b0);
    push_request(fsms_pkg::OP_NAME, "@", 1'b1);
    wait_drained();

    push_random(720);
    wait_drained();
    push_random(1420);
    wait_drained();

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
